/* src/pbfs_pkg.sv */
// Shared constants for the page buffer frame selector.
package pbfs_pkg;

    // Number of buffer frames held in the tag store; frame 0 is scratch.
    localparam int MAX_FRAMES   = 8;
    // Significant bits of a page id; wider request bits are ignored.
    localparam int PAGE_ID_BITS = 32;

    // Fixed port widths.
    localparam int ID_PORT_BITS = 32;
    localparam int FRAME_BITS   = 3;
    localparam int HIT_BITS     = 32;
    localparam int CFG_BITS     = 4;
    localparam int APB_DATA     = 32;
    localparam int APB_ADDR     = 3;

    // Width of a frame index and of a frame count (which can equal MAX_FRAMES).
    localparam int IDX_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_BITS = $clog2(MAX_FRAMES + 1);

    // Register map, as word indexes.
    localparam logic [APB_ADDR-3:0] REG_FRAMES_IN_USE = '0;

    localparam logic [CFG_BITS-1:0] FRAMES_RESET = CFG_BITS'(8);
    localparam logic [CNT_BITS-1:0] MIN_FRAMES  = CNT_BITS'(2);
    localparam logic [CNT_BITS-1:0] MAX_CNT     = CNT_BITS'(MAX_FRAMES);
    localparam logic [CNT_BITS-1:0] THREE_CNT   = CNT_BITS'(3);

endpackage

/* src/page_buffer_frame_selector.sv */
// Top level of the page buffer frame selector: tag store, victim choice and result register.
//
// Usage: each request word carries a page id and the current root page id.
// The block answers with one result word: whether the page is already held
// in a buffer frame (hit), the frame that holds or is to receive the page,
// and the running hit count after this request. Frames 1 to frames_in_use-1
// are searched; on a miss a victim frame is picked (frame 1 for the root or
// with two frames, frame 2 with three frames, else the lowest empty frame
// from 2, else a round-robin pointer that skips the last-hit page) and tagged.
// A word accepted at a clock edge appears on the output channel right after that edge.
// Throughput is one word per cycle while the receiver does not stall, set by the single
// pass of parallel tag compares between the tag registers and the result register. When
// the receiver stalls, the result register holds its word and the input stalls too, so
// no word is lost or repeated. Reset empties all frames, clears the hit count and the
// last-hit tag, sets the round-robin pointer to 1 and frames_in_use to 8. frames_in_use
// is written through the APB port at address 0; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module page_buffer_frame_selector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [pbfs_pkg::ID_PORT_BITS-1:0] i_page_id,
    input  logic [pbfs_pkg::ID_PORT_BITS-1:0] i_root_page_id,

    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_hit,
    output logic [pbfs_pkg::FRAME_BITS-1:0] o_frame,
    output logic [pbfs_pkg::HIT_BITS-1:0]  o_hit_total,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pbfs_pkg::APB_ADDR-1:0]  paddr,
    input  logic [pbfs_pkg::APB_DATA-1:0]  pwdata,
    output logic [pbfs_pkg::APB_DATA-1:0]  prdata,
    output logic                           pready
);
    import pbfs_pkg::*;

    // Configuration and persistent state.
    logic [CFG_BITS-1:0]     r_frames_in_use;
    logic [PAGE_ID_BITS-1:0] r_tags [MAX_FRAMES];
    logic [PAGE_ID_BITS-1:0] r_last_hit;
    logic [CNT_BITS-1:0]     r_vptr;
    logic [HIT_BITS-1:0]     r_hit_cnt;

    // Result register.
    logic                    r_out_valid;
    logic                    r_hit;
    logic [FRAME_BITS-1:0]   r_frame;
    logic [HIT_BITS-1:0]     r_hit_total;

    // Request decode and the chosen frame.
    logic                    accept;
    logic                    cfg_wr;
    logic [PAGE_ID_BITS-1:0] page;
    logic [PAGE_ID_BITS-1:0] root;
    logic [CNT_BITS-1:0]     eff_frames;
    logic                    hit;
    logic [IDX_BITS-1:0]     hit_idx;
    logic                    empty_found;
    logic [IDX_BITS-1:0]     empty_idx;
    logic                    rr_wrap;
    logic [CNT_BITS-1:0]     rr_start;
    logic                    rr_found_a;
    logic [IDX_BITS-1:0]     rr_idx_a;
    logic                    rr_found_b;
    logic [IDX_BITS-1:0]     rr_idx_b;
    logic [IDX_BITS-1:0]     rr_idx;
    logic [CNT_BITS-1:0]     rr_vptr;
    logic                    use_rr;
    logic [IDX_BITS-1:0]     chosen;
    logic [CNT_BITS-1:0]     n_vptr;
    logic [HIT_BITS-1:0]     n_hit_cnt;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[APB_ADDR-1:2] == REG_FRAMES_IN_USE);
    assign prdata = (paddr[APB_ADDR-1:2] == REG_FRAMES_IN_USE)
                    ? APB_DATA'(r_frames_in_use) : '0;

    assign page = i_page_id[PAGE_ID_BITS-1:0];
    assign root = i_root_page_id[PAGE_ID_BITS-1:0];

    // Out-of-range register values are clamped into 2 to MAX_FRAMES.
    always_comb begin
        if (CNT_BITS'(r_frames_in_use) < MIN_FRAMES) begin
            eff_frames = MIN_FRAMES;
        end else if (CNT_BITS'(r_frames_in_use) > MAX_CNT) begin
            eff_frames = MAX_CNT;
        end else begin
            eff_frames = CNT_BITS'(r_frames_in_use);
        end
    end

    // Parallel tag compares, each resolved by a priority pick of the lowest frame.
    always_comb begin
        hit         = 1'b0;
        hit_idx     = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int i = 1; i < MAX_FRAMES; i++) begin
            if (!hit && (page != '0) && (CNT_BITS'(i) < eff_frames)
                && (r_tags[i] == page)) begin
                hit     = 1'b1;
                hit_idx = IDX_BITS'(i);
            end
        end
        for (int i = 2; i < MAX_FRAMES; i++) begin
            if (!empty_found && (CNT_BITS'(i) < eff_frames) && (r_tags[i] == '0)) begin
                empty_found = 1'b1;
                empty_idx   = IDX_BITS'(i);
            end
        end
    end

    // Round-robin victim. The pointer first wraps to 2 if it lies beyond the
    // frames in use; the search from there skips frames holding the last-hit
    // page, and a second pass from frame 2 covers a wrap during the search.
    always_comb begin
        rr_wrap    = (r_vptr >= eff_frames);
        rr_start   = rr_wrap ? MIN_FRAMES : r_vptr;
        rr_found_a = 1'b0;
        rr_idx_a   = '0;
        rr_found_b = 1'b0;
        rr_idx_b   = '0;
        for (int i = 1; i < MAX_FRAMES; i++) begin
            if (!rr_found_a && (CNT_BITS'(i) >= rr_start) && (CNT_BITS'(i) < eff_frames)
                && (r_tags[i] != r_last_hit)) begin
                rr_found_a = 1'b1;
                rr_idx_a   = IDX_BITS'(i);
            end
        end
        for (int i = 2; i < MAX_FRAMES; i++) begin
            if (!rr_found_b && (CNT_BITS'(i) < eff_frames)
                && (r_tags[i] != r_last_hit)) begin
                rr_found_b = 1'b1;
                rr_idx_b   = IDX_BITS'(i);
            end
        end
        if (rr_found_a) begin
            rr_idx  = rr_idx_a;
            rr_vptr = rr_wrap ? MIN_FRAMES : r_vptr + CNT_BITS'(1);
        end else if (rr_found_b) begin
            rr_idx  = rr_idx_b;
            rr_vptr = MIN_FRAMES;
        end else begin
            rr_idx  = IDX_BITS'(2);
            rr_vptr = MIN_FRAMES;
        end
    end

    // Frame choice: the hit frame on a hit, else the victim frame on a miss.
    always_comb begin
        use_rr = 1'b0;
        if (hit) begin
            chosen = hit_idx;
        end else if ((eff_frames == MIN_FRAMES) || (root == page)) begin
            chosen = IDX_BITS'(1);
        end else if (eff_frames == THREE_CNT) begin
            chosen = IDX_BITS'(2);
        end else if (empty_found) begin
            chosen = empty_idx;
        end else begin
            chosen = rr_idx;
            use_rr = 1'b1;
        end
        n_vptr    = use_rr ? rr_vptr : r_vptr;
        n_hit_cnt = hit ? r_hit_cnt + HIT_BITS'(1) : r_hit_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= FRAMES_RESET;
        end else if (cfg_wr) begin
            r_frames_in_use <= pwdata[CFG_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_tags[i] <= '0;
            end
            r_last_hit <= '0;
            r_vptr     <= CNT_BITS'(1);
            r_hit_cnt  <= '0;
        end else if (accept) begin
            if (hit) begin
                r_last_hit <= r_tags[hit_idx];
            end else begin
                r_tags[chosen] <= page;
            end
            r_vptr    <= n_vptr;
            r_hit_cnt <= n_hit_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit       <= hit;
            r_frame     <= FRAME_BITS'(chosen);
            r_hit_total <= n_hit_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_frame     = r_frame;
    assign o_hit_total = r_hit_total;

endmodule
